/* design/szd_pkg.sv */
// ---------------------------------------------------------------------------
// szd_pkg
// Shared types, constants and zone tables of the I2C slider zone decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package szd_pkg;

    typedef enum logic [1:0] {
        EV_BEGIN = 2'd0,
        EV_STOP  = 2'd1,
        EV_DATA  = 2'd2,
        EV_NONE  = 2'd3
    } t_event_kind;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_ADDR   = 1'b1;

    localparam logic [7:0] REQUEST_ADDR_RST = 8'h58;
    localparam logic [7:0] REPLY_ADDR_RST   = 8'h59;

    localparam logic [7:0] HALF_FIRST  = 8'h01;
    localparam logic [7:0] INDEX_MAX   = 8'hFF;
    localparam logic [4:0] HALF_OFFSET = 5'd8;

    typedef struct packed {
        logic [7:0] request_address;
        logic [7:0] reply_address;
    } t_cfg;

    // Zone group set or cleared by the low nibble
    function automatic logic [31:0] grp_low(input logic [4:0] pos);
        logic [31:0] m;
        begin
            case (pos)
                5'd1:    m = 32'h1 << 30;
                5'd4:    m = 32'h3 << 24;
                5'd7:    m = 32'h3 << 18;
                5'd9:    m = 32'h3 << 12;
                5'd12:   m = 32'h3 << 6;
                5'd15:   m = 32'h1 << 1;
                default: m = 32'h0;
            endcase
            return m;
        end
    endfunction

    // Zone group set or cleared by the high nibble
    function automatic logic [31:0] grp_high(input logic [4:0] pos);
        logic [31:0] m;
        begin
            case (pos)
                5'd1:    m = 32'h1 << 31;
                5'd2:    m = 32'h3 << 28;
                5'd4:    m = 32'h3 << 26;
                5'd5:    m = 32'h3 << 22;
                5'd7:    m = 32'h3 << 20;
                5'd8:    m = 32'h3 << 16;
                5'd9:    m = 32'h3 << 14;
                5'd10:   m = 32'h3 << 10;
                5'd12:   m = 32'h3 << 8;
                5'd13:   m = 32'h3 << 4;
                5'd15:   m = 32'h3 << 2;
                5'd16:   m = 32'h1;
                default: m = 32'h0;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

/* design/szd_cfg.sv */
// ---------------------------------------------------------------------------
// szd_cfg
// Address registers written through the configuration port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module szd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [szd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    output szd_pkg::t_cfg                       o_cfg
);
    import szd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_address <= REQUEST_ADDR_RST;
            r_cfg.reply_address   <= REPLY_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REQUEST_ADDR: r_cfg.request_address <= i_cfg_data;
                CFG_REPLY_ADDR:   r_cfg.reply_address   <= i_cfg_data;
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/szd_core.sv */
// ---------------------------------------------------------------------------
// szd_core
// Bus tracking state and slider image update, one event per cycle while i_step is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module szd_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [1:0]     i_event_kind,
    input  wire logic [7:0]     i_data_byte,
    input  wire szd_pkg::t_cfg  i_cfg,
    output logic [31:0]         o_next_image
);
    import szd_pkg::*;

    logic        r_expect_address, n_expect_address;
    logic [7:0]  r_current_address, n_current_address;
    logic [7:0]  r_byte_index, n_byte_index;
    logic        r_second_half, n_second_half;
    logic [31:0] r_slider_image, n_slider_image;

    t_event_kind kind;
    logic [4:0]  pos;
    logic        low_too;
    logic        high_only;
    logic [31:0] m_low;
    logic [31:0] m_high;
    logic [31:0] img;

    assign kind = t_event_kind'(i_event_kind);
    assign pos  = r_byte_index[4:0] + (r_second_half ? HALF_OFFSET : 5'd0);
    assign m_low  = grp_low(pos);
    assign m_high = grp_high(pos);

    always_comb begin
        low_too   = (r_byte_index inside {8'd1, 8'd4, 8'd7});
        high_only = (r_byte_index inside {8'd2, 8'd5, 8'd8});
    end

    always_comb begin
        n_expect_address  = r_expect_address;
        n_current_address = r_current_address;
        n_byte_index      = r_byte_index;
        n_second_half     = r_second_half;
        img               = r_slider_image;
        case (kind)
            EV_BEGIN: begin
                n_expect_address = 1'b1;
            end
            EV_STOP: begin
                n_current_address = 8'd0;
            end
            EV_DATA: begin
                if (r_expect_address) begin
                    n_current_address = i_data_byte;
                    n_expect_address  = 1'b0;
                end else if (r_current_address == i_cfg.request_address) begin
                    n_second_half = (i_data_byte != HALF_FIRST);
                end else if (r_current_address == i_cfg.reply_address) begin
                    if (low_too) begin
                        img = (i_data_byte[3:0] != 4'd0) ? (img | m_low) : (img & ~m_low);
                    end
                    if (low_too || high_only) begin
                        img = (i_data_byte[7:4] != 4'd0) ? (img | m_high)
                                                          : (img & ~m_high);
                    end
                end
                // saturate the index
                if (r_expect_address) begin
                    n_byte_index = 8'd1;
                end else if (r_byte_index != INDEX_MAX) begin
                    n_byte_index = r_byte_index + 8'd1;
                end
            end
            default: begin
                img = r_slider_image;
            end
        endcase
        n_slider_image = img;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_address  <= 1'b0;
            r_current_address <= 8'd0;
            r_byte_index      <= 8'd0;
            r_second_half     <= 1'b0;
            r_slider_image    <= 32'd0;
        end else if (i_step) begin
            r_expect_address  <= n_expect_address;
            r_current_address <= n_current_address;
            r_byte_index      <= n_byte_index;
            r_second_half     <= n_second_half;
            r_slider_image    <= n_slider_image;
        end
    end

    assign o_next_image = n_slider_image;

endmodule

`default_nettype wire

/* design/i2c_slider_zone_decoder_top.sv */
// ---------------------------------------------------------------------------
// i2c_slider_zone_decoder_top
// Decodes sniffed I2C events into a 32-bit slider zone image.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// event     in         i_valid / o_ready    i_event_kind, i_data_byte
// image     out        o_valid / i_ready    o_slider_bits
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One item per cycle unless the result stalls (input register, then state
// update into the result register). One image is returned for every item.
// Reset is synchronous: addresses reset to 0x58 / 0x59, core state clears.
// A stalled result holds the update stage; the input stays ready while
// the input register is empty or the result register can drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_slider_zone_decoder_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_event_kind,
    input  wire logic [7:0]                     i_data_byte,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [31:0]                         o_slider_bits,
    input  wire logic                           i_cfg_we,
    input  wire logic [szd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data
);
    import szd_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    logic [31:0] r_out_bits;

    logic        out_load;
    logic        advance;
    logic [31:0] next_image;
    t_cfg        cfg;

    assign out_load = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_load;
    assign o_ready  = !r_in_valid || out_load;

    szd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    szd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_event_kind (r_in_kind),
        .i_data_byte  (r_in_data),
        .i_cfg        (cfg),
        .o_next_image (next_image)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_kind <= i_event_kind;
            r_in_data <= i_data_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bits <= next_image;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slider_bits = r_out_bits;

endmodule

`default_nettype wire
